// ----- sv/ldpp_pkg.sv -----
// Shared widths, register codes and pipeline stage types for the lens projection block.
package ldpp_pkg;

    localparam int COORD_WIDTH    = 20;
    localparam int COEF_FRAC_BITS = 14;

    localparam int NF  = 16;
    localparam int CF  = COEF_FRAC_BITS;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 16 + DW;
    localparam int SW  = PW + 2;
    localparam int QW  = 2 + NF;
    localparam int XW  = QW + 1;
    localparam int RW  = SW + QW;

    localparam int SQW   = 2 * XW;
    localparam int R2W   = 2 * XW - NF + 1;
    localparam int XYW   = 2 * XW - NF;
    localparam int R2SQW = 2 * R2W;
    localparam int R4W   = 2 * R2W - NF;
    localparam int R46W  = R4W + R2W;
    localparam int R6W   = R46W - NF;
    localparam int KR1W  = 16 + R2W;
    localparam int KR2W  = 16 + R4W;
    localparam int KR3W  = 16 + R6W;
    localparam int KSW   = KR3W + 2;
    localparam int FW    = KSW - CF + 2;
    localparam int TAW   = R2W + 2;
    localparam int T1W   = 16 + XYW;
    localparam int T2W   = 16 + TAW;
    localparam int TSW   = T2W + 2;
    localparam int TW    = TSW - CF + 1;
    localparam int MUW   = XW + FW;
    localparam int UW    = MUW - NF + 2;
    localparam int FUW   = 17 + UW;
    localparam int PXW   = FUW - NF + 2;

    localparam int LS  = 13;
    localparam int LAT = 3 + (QW + 1) + LS;

    localparam logic [QW-1:0] NORM_LIMIT = {QW{1'b1}};
    localparam logic signed [23:0] PIX_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] PIX_MIN = -24'sh800000;

    localparam logic [2:0] REG_INTR = 3'd0;
    localparam logic [2:0] REG_ROT0 = 3'd1;
    localparam logic [2:0] REG_ROT1 = 3'd2;
    localparam logic [2:0] REG_ROT2 = 3'd3;
    localparam logic [2:0] REG_TRAN = 3'd4;
    localparam logic [2:0] REG_RAD  = 3'd5;
    localparam logic [2:0] REG_TAN  = 3'd6;

    typedef struct packed {
        logic          vld;
        logic          zero;
        logic          negx;
        logic          negy;
        logic          ovfx;
        logic          ovfy;
        logic [SW-1:0] ub;
        logic [RW-1:0] remx;
        logic [RW-1:0] remy;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
    } dv_t;

    typedef struct packed {
        logic                    vld;
        logic                    zero;
        logic                    bad;
        logic signed [XW-1:0]    xn;
        logic signed [XW-1:0]    yn;
        logic signed [SQW-1:0]   sqx;
        logic signed [SQW-1:0]   sqy;
        logic signed [SQW-1:0]   pxy;
        logic signed [R2W-1:0]   r2;
        logic signed [XYW-1:0]   xx;
        logic signed [XYW-1:0]   yy;
        logic signed [XYW-1:0]   xy;
        logic signed [R2SQW-1:0] r2sq;
        logic signed [KR1W-1:0]  kr1;
        logic signed [T1W-1:0]   t1u;
        logic signed [T2W-1:0]   t2u;
        logic signed [T1W-1:0]   t1v;
        logic signed [T2W-1:0]   t2v;
        logic signed [R4W-1:0]   r4;
        logic signed [TW-1:0]    tu;
        logic signed [TW-1:0]    tv;
        logic signed [R46W-1:0]  r46;
        logic signed [KR2W-1:0]  kr2;
        logic signed [R6W-1:0]   r6;
        logic signed [KR3W-1:0]  kr3;
        logic signed [FW-1:0]    f;
        logic signed [MUW-1:0]   mu;
        logic signed [MUW-1:0]   mv;
        logic signed [UW-1:0]    ud;
        logic signed [UW-1:0]    vd;
        logic signed [FUW-1:0]   fu;
        logic signed [FUW-1:0]   fv;
        logic signed [23:0]      pu;
        logic signed [23:0]      pv;
        logic                    ok;
    } pt_t;

endpackage

// ----- sv/lens_distortion_point_projection.sv -----
// Top level: pipelined world-to-pixel projection with Brown-Conrady distortion.
//
// Usage: drive point_x/y/z with start high; an item is taken at every edge where
// start is high and busy is low. busy stays low: a new item may enter every cycle.
// Each item gives one result: done is high for one cycle with pixel_u, pixel_v
// and valid_res, in input order. Throughput is one item per cycle; the 18
// restoring divide stages (one quotient bit each) set most of the latency, the
// rest are offset, multiply, sum, divider setup, round and clamp stages.
// valid_res is 0 for zero depth (pixels then read 8388607), for a normalized
// coordinate clamped at four, or for a saturated pixel.
// Configuration: cfg_we with cfg_index and cfg_data writes one register at the
// edge; write only while no item is in flight. Unknown indexes are ignored.
// Reset (rst_n low, asynchronous) empties the pipeline and loads identity
// rotation and zero in every other register. The receiver cannot stall: each
// result is shown for exactly one cycle.
module lens_distortion_point_projection
    import ldpp_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [63:0]                   cfg_data,
    output logic                          done,
    output logic signed [23:0]            pixel_u,
    output logic signed [23:0]            pixel_v,
    output logic                          valid_res
);

    localparam logic [47:0] ROT_ONE = 48'(1) << CF;

    logic [63:0] intr_reg;
    logic [47:0] rot_reg [3];
    logic [59:0] tran_reg;
    logic [47:0] rad_reg;
    logic [31:0] tan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intr_reg   <= '0;
            rot_reg[0] <= ROT_ONE;
            rot_reg[1] <= ROT_ONE << 16;
            rot_reg[2] <= ROT_ONE << 32;
            tran_reg   <= '0;
            rad_reg    <= '0;
            tan_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INTR: intr_reg   <= cfg_data;
                REG_ROT0: rot_reg[0] <= cfg_data[47:0];
                REG_ROT1: rot_reg[1] <= cfg_data[47:0];
                REG_ROT2: rot_reg[2] <= cfg_data[47:0];
                REG_TRAN: tran_reg   <= cfg_data[59:0];
                REG_RAD:  rad_reg    <= cfg_data[47:0];
                REG_TAN:  tan_reg    <= cfg_data[31:0];
                default:  ;
            endcase
        end
    end

    assign busy = 1'b0;

    // front: offset, rotate products, sums
    logic                    e0_vld_reg, e1_vld_reg, e2_vld_reg;
    logic signed [DW-1:0]    d_reg    [3];
    logic signed [DW-1:0]    d_next   [3];
    logic signed [PW-1:0]    prod_reg [3][3];
    logic signed [SW-1:0]    c_reg    [3];
    logic signed [SW-1:0]    c_next   [3];
    logic [63:0]             tran_ext;
    logic signed [COORD_WIDTH-1:0] pin [3];

    always_comb
    begin
        tran_ext = {4'b0, tran_reg};
        pin[0] = point_x;
        pin[1] = point_y;
        pin[2] = point_z;
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = DW'(pin[i]) -
                DW'($signed(COORD_WIDTH'(tran_ext >> (i * COORD_WIDTH))));
            c_next[i] = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_vld_reg <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
        end
        else
        begin
            e0_vld_reg <= start;
            e1_vld_reg <= e0_vld_reg;
            e2_vld_reg <= e1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= d_next[i];
            c_reg[i] <= c_next[i];
            for (int j = 0; j < 3; j++)
                prod_reg[i][j] <= $signed(rot_reg[i][16*j +: 16]) * d_reg[j];
        end
    end

    // restoring divider, one quotient bit per stage
    dv_t dv_reg  [QW+1];
    dv_t dv_next [QW+1];

    always_comb
    begin
        logic [SW-1:0] ua;
        logic [SW-1:0] va;
        logic [SW-1:0] wa;
        logic [RW-1:0] dsh;
        ua = c_reg[0][SW-1] ? SW'(-c_reg[0]) : SW'(c_reg[0]);
        va = c_reg[1][SW-1] ? SW'(-c_reg[1]) : SW'(c_reg[1]);
        wa = c_reg[2][SW-1] ? SW'(-c_reg[2]) : SW'(c_reg[2]);
        dv_next[0].vld  = e2_vld_reg;
        dv_next[0].zero = (c_reg[2] == '0);
        dv_next[0].negx = c_reg[0][SW-1] != c_reg[2][SW-1];
        dv_next[0].negy = c_reg[1][SW-1] != c_reg[2][SW-1];
        dv_next[0].ovfx = {2'b0, ua} >= {wa, 2'b0};
        dv_next[0].ovfy = {2'b0, va} >= {wa, 2'b0};
        dv_next[0].ub   = wa;
        dv_next[0].remx = RW'(ua) << NF;
        dv_next[0].remy = RW'(va) << NF;
        dv_next[0].qx   = '0;
        dv_next[0].qy   = '0;
        for (int k = 1; k <= QW; k++)
        begin
            dv_next[k] = dv_reg[k-1];
            dsh = RW'(dv_reg[k-1].ub) << (QW - k);
            if (dv_reg[k-1].remx >= dsh)
            begin
                dv_next[k].remx = dv_reg[k-1].remx - dsh;
                dv_next[k].qx[QW-k] = 1'b1;
            end
            if (dv_reg[k-1].remy >= dsh)
            begin
                dv_next[k].remy = dv_reg[k-1].remy - dsh;
                dv_next[k].qy[QW-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                dv_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k <= QW; k++)
                dv_reg[k] <= dv_next[k];
        end
    end

    // distortion and intrinsics
    pt_t s_reg  [LS];
    pt_t s_next [LS];

    always_comb
    begin
        logic signed [XW-1:0]    qxs;
        logic signed [XW-1:0]    qys;
        logic signed [SQW+1:0]   t2;
        logic signed [SQW:0]     txx;
        logic signed [SQW:0]     tyy;
        logic signed [SQW:0]     txy;
        logic signed [TAW-1:0]   tax;
        logic signed [TAW-1:0]   tay;
        logic signed [R2SQW:0]   t4;
        logic signed [TSW:0]     tsu;
        logic signed [TSW:0]     tsv;
        logic signed [R46W:0]    t6;
        logic signed [KSW:0]     tks;
        logic signed [MUW:0]     tmu;
        logic signed [MUW:0]     tmv;
        logic signed [16:0]      fxs;
        logic signed [16:0]      fys;
        logic signed [FUW:0]     tfu;
        logic signed [FUW:0]     tfv;
        logic signed [PXW-1:0]   px;
        logic signed [PXW-1:0]   py;

        qxs = dv_reg[QW].ovfx ? $signed({1'b0, NORM_LIMIT}) : $signed({1'b0, dv_reg[QW].qx});
        qys = dv_reg[QW].ovfy ? $signed({1'b0, NORM_LIMIT}) : $signed({1'b0, dv_reg[QW].qy});
        s_next[0]      = '0;
        s_next[0].vld  = dv_reg[QW].vld;
        s_next[0].zero = dv_reg[QW].zero;
        s_next[0].bad  = dv_reg[QW].ovfx | dv_reg[QW].ovfy;
        s_next[0].xn   = dv_reg[QW].negx ? -qxs : qxs;
        s_next[0].yn   = dv_reg[QW].negy ? -qys : qys;
        for (int k = 1; k < LS; k++)
            s_next[k] = s_reg[k-1];

        s_next[1].sqx = s_reg[0].xn * s_reg[0].xn;
        s_next[1].sqy = s_reg[0].yn * s_reg[0].yn;
        s_next[1].pxy = s_reg[0].xn * s_reg[0].yn;

        t2  = s_reg[1].sqx;
        t2  = t2 + s_reg[1].sqy + ((SQW+2)'(1) <<< (NF-1));
        txx = s_reg[1].sqx;
        txx = txx + ((SQW+1)'(1) <<< (NF-1));
        tyy = s_reg[1].sqy;
        tyy = tyy + ((SQW+1)'(1) <<< (NF-1));
        txy = s_reg[1].pxy;
        txy = txy + ((SQW+1)'(1) <<< (NF-1));
        s_next[2].r2 = R2W'($signed(t2[SQW+1:NF]));
        s_next[2].xx = XYW'($signed(txx[SQW:NF]));
        s_next[2].yy = XYW'($signed(tyy[SQW:NF]));
        s_next[2].xy = XYW'($signed(txy[SQW:NF]));

        tax = s_reg[2].xx;
        tax = (tax <<< 1) + s_reg[2].r2;
        tay = s_reg[2].yy;
        tay = (tay <<< 1) + s_reg[2].r2;
        s_next[3].r2sq = s_reg[2].r2 * s_reg[2].r2;
        s_next[3].kr1  = $signed(rad_reg[15:0]) * s_reg[2].r2;
        s_next[3].t1u  = $signed(tan_reg[15:0]) * s_reg[2].xy;
        s_next[3].t2u  = $signed(tan_reg[31:16]) * tax;
        s_next[3].t1v  = $signed(tan_reg[31:16]) * s_reg[2].xy;
        s_next[3].t2v  = $signed(tan_reg[15:0]) * tay;

        t4  = s_reg[3].r2sq;
        t4  = t4 + ((R2SQW+1)'(1) <<< (NF-1));
        tsu = s_reg[3].t1u;
        tsu = (tsu <<< 1) + s_reg[3].t2u + ((TSW+1)'(1) <<< (CF-1));
        tsv = s_reg[3].t1v;
        tsv = (tsv <<< 1) + s_reg[3].t2v + ((TSW+1)'(1) <<< (CF-1));
        s_next[4].r4 = R4W'($signed(t4[R2SQW:NF]));
        s_next[4].tu = TW'($signed(tsu[TSW:CF]));
        s_next[4].tv = TW'($signed(tsv[TSW:CF]));

        s_next[5].r46 = s_reg[4].r4 * s_reg[4].r2;
        s_next[5].kr2 = $signed(rad_reg[31:16]) * s_reg[4].r4;

        t6 = s_reg[5].r46;
        t6 = t6 + ((R46W+1)'(1) <<< (NF-1));
        s_next[6].r6 = R6W'($signed(t6[R46W:NF]));

        s_next[7].kr3 = $signed(rad_reg[47:32]) * s_reg[6].r6;

        tks = s_reg[7].kr1;
        tks = tks + s_reg[7].kr2 + s_reg[7].kr3 + ((KSW+1)'(1) <<< (CF-1));
        s_next[8].f = FW'($signed(tks[KSW:CF])) + (FW'(1) <<< NF);

        s_next[9].mu = s_reg[8].xn * s_reg[8].f;
        s_next[9].mv = s_reg[8].yn * s_reg[8].f;

        tmu = s_reg[9].mu;
        tmu = tmu + ((MUW+1)'(1) <<< (NF-1));
        tmv = s_reg[9].mv;
        tmv = tmv + ((MUW+1)'(1) <<< (NF-1));
        s_next[10].ud = UW'($signed(tmu[MUW:NF])) + UW'(s_reg[9].tu);
        s_next[10].vd = UW'($signed(tmv[MUW:NF])) + UW'(s_reg[9].tv);

        fxs = $signed({1'b0, intr_reg[15:0]});
        fys = $signed({1'b0, intr_reg[31:16]});
        s_next[11].fu = fxs * s_reg[10].ud;
        s_next[11].fv = fys * s_reg[10].vd;

        tfu = s_reg[11].fu;
        tfu = tfu + ((FUW+1)'(1) <<< (NF-1));
        tfv = s_reg[11].fv;
        tfv = tfv + ((FUW+1)'(1) <<< (NF-1));
        px  = PXW'($signed(tfu[FUW:NF])) + PXW'($signed({1'b0, intr_reg[47:32]}));
        py  = PXW'($signed(tfv[FUW:NF])) + PXW'($signed({1'b0, intr_reg[63:48]}));
        s_next[12].ok = ~s_reg[11].bad;
        priority if (px > PXW'(PIX_MAX))
        begin
            s_next[12].pu = PIX_MAX;
            s_next[12].ok = 1'b0;
        end
        else if (px < PXW'(PIX_MIN))
        begin
            s_next[12].pu = PIX_MIN;
            s_next[12].ok = 1'b0;
        end
        else
            s_next[12].pu = px[23:0];
        priority if (py > PXW'(PIX_MAX))
        begin
            s_next[12].pv = PIX_MAX;
            s_next[12].ok = 1'b0;
        end
        else if (py < PXW'(PIX_MIN))
        begin
            s_next[12].pv = PIX_MIN;
            s_next[12].ok = 1'b0;
        end
        else
            s_next[12].pv = py[23:0];
        if (s_reg[11].zero)
        begin
            s_next[12].pu = PIX_MAX;
            s_next[12].pv = PIX_MAX;
            s_next[12].ok = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LS; k++)
                s_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < LS; k++)
                s_reg[k] <= s_next[k];
        end
    end

    assign done      = s_reg[LS-1].vld;
    assign pixel_u   = s_reg[LS-1].pu;
    assign pixel_v   = s_reg[LS-1].pv;
    assign valid_res = s_reg[LS-1].ok;

endmodule

// ----- sv/ldpp_checker.sv -----
// Port-level checker for the lens projection block, bound to the top level.
module ldpp_checker
    import ldpp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("item without result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result without item");

endmodule

bind lens_distortion_point_projection ldpp_checker u_ldpp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
